// ===== design/lrukv_pkg.sv =====
// Shared constants and types for the LRU key-value cache.
package lrukv_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int RANK_W   = IDX_W;
  localparam int KEY_W    = 16;
  localparam int VAL_W    = 16;
  localparam int CFG_W    = 5;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // register index, taken from paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_CAPACITY = '0;

  typedef logic [CAPACITY-1:0][RANK_W-1:0] rank_vec_t;

  // recency update request: touch makes idx most recent among valid entries,
  // insert validates idx as most recent and ages every other valid entry
  typedef struct packed {
    logic             touch;
    logic             insert;
    logic [IDX_W-1:0] idx;
  } rank_cmd_t;

endpackage

// ===== design/lrukv_rank_table.sv =====
// Per-entry valid bits and recency ranks with their update logic.
module lrukv_rank_table
  import lrukv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  rank_cmd_t           cmd,
  output logic [CAPACITY-1:0] valid,
  output rank_vec_t           ranks
);

  logic [CAPACITY-1:0] valid_next;
  rank_vec_t           ranks_next;
  logic [RANK_W-1:0]   ref_rank;

  assign ref_rank = ranks[cmd.idx];

  always_comb begin
    valid_next = valid;
    ranks_next = ranks;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.touch) begin
        if (IDX_W'(i) == cmd.idx) begin
          ranks_next[i] = '0;
        end else if (valid[i] && ranks[i] < ref_rank) begin
          ranks_next[i] = ranks[i] + RANK_W'(1);
        end
      end else if (cmd.insert) begin
        if (IDX_W'(i) == cmd.idx) begin
          ranks_next[i] = '0;
          valid_next[i] = 1'b1;
        end else if (valid[i]) begin
          ranks_next[i] = ranks[i] + RANK_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ranks <= '0;
    end else begin
      valid <= valid_next;
      ranks <= ranks_next;
    end
  end

endmodule

// ===== design/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
//
// Command channel: a transaction is taken at a rising edge with start high
// and busy low, carrying opcode (get or put), key and value. busy rises on
// the next cycle and stays high until the command has finished.
// Result channel: each get yields one result, shown on found and read_value
// for exactly one cycle while done is high; a put yields none. The receiver
// cannot stall, so done is never held.
// Timing: keys sit in a synchronous-read memory, with separate read and
// write addresses, that is scanned one entry per cycle; then a commit
// state updates the memories and ranks. A get shows its result in a
// response state after the commit; a put frees the block when the commit
// ends. One command is worked on at a time.
// Configuration: APB port, register capacity_in_use at byte address 0;
// the user must write it only while the block is idle, as the block does
// not enforce this. Zero acts as one, values above CAPACITY act as CAPACITY.
// Reset: rst clears all valid bits, ranks and the fill count, and restores
// capacity_in_use to 16. No clearing pass is needed.
module lru_key_value_cache
  import lrukv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [KEY_W-1:0]  key,
  input  logic [VAL_W-1:0]  value,
  output logic              done,
  output logic              found,
  output logic [VAL_W-1:0]  read_value,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_RESP   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CFG_W-1:0] capacity_in_use;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] entry_count;

  logic             op_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] value_q;

  logic [CNT_W-1:0] scan_cnt;
  logic [IDX_W-1:0] cmp_idx;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] val_mem [CAPACITY];
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;

  logic              match_hit, free_hit, victim_hit;
  logic [IDX_W-1:0]  match_idx, free_idx, victim_idx;
  logic [RANK_W-1:0] victim_rank;

  logic [CAPACITY-1:0] valid;
  rank_vec_t           ranks;
  rank_cmd_t           rank_cmd;

  logic accept, in_commit, is_put, use_free, use_victim;
  logic key_we, val_we;
  logic [IDX_W-1:0] wr_idx;
  logic found_q;
  logic cfg_wr;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign in_commit = (state == S_COMMIT);
  assign is_put    = (op_q == OP_PUT);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_CAPACITY);
  assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ?
                  DATA_W'(capacity_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity_in_use <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (capacity_in_use == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CNT_W'(capacity_in_use) > CNT_W'(CAPACITY)) begin
      cap_eff = CNT_W'(CAPACITY);
    end else begin
      cap_eff = CNT_W'(capacity_in_use);
    end
  end

  // commit decisions
  assign use_free   = in_commit && is_put && !match_hit && free_hit &&
                      (entry_count < cap_eff);
  assign use_victim = in_commit && is_put && !match_hit && !use_free && victim_hit;
  assign wr_idx     = match_hit ? match_idx : (use_free ? free_idx : victim_idx);
  assign key_we     = use_free || use_victim;
  assign val_we     = key_we || (in_commit && is_put && match_hit);

  assign rank_cmd.touch  = (in_commit && match_hit) || use_victim;
  assign rank_cmd.insert = use_free;
  assign rank_cmd.idx    = wr_idx;

  lrukv_rank_table u_rank (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rank_cmd),
    .valid (valid),
    .ranks (ranks)
  );

  // memories
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_idx] <= key_q;
    end
    key_rd <= key_mem[scan_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[wr_idx] <= value_q;
    end
    val_rd <= val_mem[match_idx];
  end

  // entry compared this cycle was addressed on the previous one
  assign cmp_idx = scan_cnt[IDX_W-1:0] - IDX_W'(1);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_SCAN;
      S_SCAN:   if (scan_cnt == CNT_W'(CAPACITY)) state_next = S_COMMIT;
      S_COMMIT: state_next = is_put ? S_IDLE : S_RESP;
      S_RESP:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      scan_cnt    <= '0;
      match_hit   <= 1'b0;
      free_hit    <= 1'b0;
      victim_hit  <= 1'b0;
    end else begin
      state <= state_next;
      if (use_free) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      if (accept) begin
        scan_cnt   <= '0;
        match_hit  <= 1'b0;
        free_hit   <= 1'b0;
        victim_hit <= 1'b0;
      end else if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
        if (scan_cnt != '0) begin
          if (valid[cmp_idx] && key_rd == key_q && !match_hit) begin
            match_hit <= 1'b1;
          end
          if (!valid[cmp_idx] && !free_hit) begin
            free_hit <= 1'b1;
          end
          if (valid[cmp_idx] && (!victim_hit || ranks[cmp_idx] > victim_rank)) begin
            victim_hit <= 1'b1;
          end
        end
      end
    end
  end

  // payload side of the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= opcode;
      key_q   <= key;
      value_q <= value;
    end
    if (state == S_SCAN && scan_cnt != '0) begin
      if (valid[cmp_idx] && key_rd == key_q && !match_hit) begin
        match_idx <= cmp_idx;
      end
      if (!valid[cmp_idx] && !free_hit) begin
        free_idx <= cmp_idx;
      end
      if (valid[cmp_idx] && (!victim_hit || ranks[cmp_idx] > victim_rank)) begin
        victim_idx  <= cmp_idx;
        victim_rank <= ranks[cmp_idx];
      end
    end
    if (in_commit) begin
      found_q <= match_hit;
    end
  end

  assign done       = (state == S_RESP);
  assign found      = found_q;
  assign read_value = found_q ? val_rd : '0;

  // checks
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(entry_count))
    else $error("fill count disagrees with valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_result_only_for_get: assert property (@(posedge clk) disable iff (rst)
    done |-> (op_q == OP_GET))
    else $error("result strobe for a put transaction");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy did not rise after an accepted transaction");

endmodule

// ===== tb/tb_lru_key_value_cache.sv =====
// Self-checking testbench for the LRU key-value cache: directed table, then random phases.
module tb_lru_key_value_cache;
  import lrukv_pkg::*;

  localparam logic [ADDR_W-1:0] CAP_ADDR = {REG_CAPACITY, 2'b00};
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 170;
  localparam int POOL_SIZE       = CAPACITY + 4;
  localparam int SETTLE_CYCLES   = CAPACITY + 4;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
  } result_t;

  typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

  // val carries the capacity on a ROW_CAP row; chk marks a typed-in expectation
  typedef struct packed {
    row_kind_t        kind;
    logic             op;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] val;
    logic             chk;
    logic             exp_found;
    logic [VAL_W-1:0] exp_value;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              opcode = OP_GET;
  logic [KEY_W-1:0]  key = '0;
  logic [VAL_W-1:0]  value = '0;
  logic              done;
  logic              found;
  logic [VAL_W-1:0]  read_value;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lru_key_value_cache u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .opcode     (opcode),
    .key        (key),
    .value      (value),
    .done       (done),
    .found      (found),
    .read_value (read_value),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  logic [KEY_W-1:0] cache_key  [CAPACITY];
  logic [VAL_W-1:0] cache_val  [CAPACITY];
  bit               cache_live [CAPACITY];
  int unsigned      cache_age  [CAPACITY];
  int unsigned      cache_fill;
  logic [CFG_W-1:0] cap_reg;

  result_t pending_reads [$];
  int      fail_count = 0;

  function automatic int unsigned usable_slots(input logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (c > CAPACITY) return CAPACITY;
    return c;
  endfunction

  function automatic int lookup_slot(input logic [KEY_W-1:0] k);
    for (int i = 0; i < CAPACITY; i++)
      if (cache_live[i] && cache_key[i] == k) return i;
    return -1;
  endfunction

  // entries more recent than idx age by one, idx becomes most recent
  function automatic void promote(input int idx);
    int unsigned r;
    r = cache_age[idx];
    for (int i = 0; i < CAPACITY; i++)
      if (cache_live[i] && i != idx && cache_age[i] < r) cache_age[i]++;
    cache_age[idx] = 0;
  endfunction

  function automatic void store_new(input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
    int slot;
    slot = -1;
    if (cache_fill < usable_slots(cap_reg))
      for (int i = 0; i < CAPACITY; i++)
        if (!cache_live[i] && slot < 0) slot = i;
    if (slot >= 0) begin
      for (int i = 0; i < CAPACITY; i++)
        if (cache_live[i]) cache_age[i]++;
      cache_live[slot] = 1'b1;
      cache_age[slot]  = 0;
      cache_key[slot]  = k;
      cache_val[slot]  = v;
      cache_fill++;
      return;
    end
    // evict: oldest rank, lowest index on a tie
    for (int i = 0; i < CAPACITY; i++)
      if (cache_live[i] && (slot < 0 || cache_age[i] > cache_age[slot])) slot = i;
    if (slot < 0) return;
    cache_key[slot] = k;
    cache_val[slot] = v;
    promote(slot);
  endfunction

  function automatic void cache_model_step(input logic op, input logic [KEY_W-1:0] k,
                                           input logic [VAL_W-1:0] v,
                                           output bit gives, output result_t r);
    int idx;
    idx   = lookup_slot(k);
    gives = 1'b0;
    r     = '0;
    if (op == OP_GET) begin
      gives = 1'b1;
      if (idx >= 0) begin
        promote(idx);
        r.found      = 1'b1;
        r.read_value = cache_val[idx];
      end
    end else if (idx >= 0) begin
      cache_val[idx] = v;
      promote(idx);
    end else begin
      store_new(k, v);
    end
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < CAPACITY; i++) begin
      cache_key[i]  = '0;
      cache_val[i]  = '0;
      cache_live[i] = 1'b0;
      cache_age[i]  = 0;
    end
    cache_fill = 0;
    cap_reg    = CAP_RESET;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_cmd(input logic op, input logic [KEY_W-1:0] k,
                          input logic [VAL_W-1:0] v, input bit typed, input result_t typed_res);
    bit      gives;
    result_t r;
    @(negedge clk);
    start  <= 1'b1;
    opcode <= op;
    key    <= k;
    value  <= v;
    do @(posedge clk); while (busy);
    cache_model_step(op, k, v, gives, r);
    if (gives) pending_reads.push_back(typed ? typed_res : r);
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_results_out();
    @(negedge clk);
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  // a put leaves no result behind, so allow its latency before touching config
  task automatic wait_idle();
    wait_results_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CFG_W-1:0] c);
    logic [DATA_W-1:0] wr_word;
    wr_word = {$urandom} << CFG_W;
    wr_word[CFG_W-1:0] = c;
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= wr_word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = c;
    // read back
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(c)) begin
      $display("%0t: capacity readback expected %h actual %h", $time, DATA_W'(c), prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checker
  result_t want;

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result found=%0b read_value=%h", $time, found, read_value);
        fail_count++;
      end else begin
        want = pending_reads.pop_front();
        if (found !== want.found) begin
          $display("%0t: found expected %0b actual %0b", $time, want.found, found);
          fail_count++;
        end
        if (read_value !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   read_value);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  dir_row_t dir_rows [28] = '{
    '{ROW_ITEM, OP_GET, 16'h0000, 16'hFFFF, 1'b1, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_PUT, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF},
    '{ROW_ITEM, OP_PUT, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0000},
    '{ROW_ITEM, OP_PUT, 16'h0000, 16'hA5A5, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'hA5A5},
    // zero acts as one, and the fill is already above it
    '{ROW_CAP,  OP_GET, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_PUT, 16'h1234, 16'h5A5A, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'hFFFF, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h1234, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_PUT, 16'h0000, 16'h1111, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_PUT, 16'h8001, 16'h7FFE, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h1234, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    // above CAPACITY clamps
    '{ROW_CAP,  OP_GET, 16'h0000, 16'h001F, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_PUT, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_PUT, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h5555, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'hAAAA, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h8001, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_CAP,  OP_GET, 16'h0000, 16'h0002, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_PUT, 16'h0F0F, 16'hF0F0, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_ITEM, OP_GET, 16'hF0F0, 16'h0000, 1'b0, 1'b0, 16'h0000},
    '{ROW_CAP,  OP_GET, 16'h0000, 16'h0010, 1'b0, 1'b0, 16'h0000}
  };

  int unsigned      phase_cap  [NUM_PHASES] = '{16, 3, 1, 17, 0, 8, 2, 31};
  int unsigned      phase_idle [NUM_PHASES] = '{0, 60, 21, 60, 0, 21, 60, 0};
  logic [KEY_W-1:0] key_pool   [POOL_SIZE];

  initial begin
    int unsigned      span;
    logic [KEY_W-1:0] k;
    clear_model();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP)
        set_capacity(dir_rows[i].val[CFG_W-1:0]);
      else
        send_cmd(dir_rows[i].op, dir_rows[i].k, dir_rows[i].val, dir_rows[i].chk,
                 {dir_rows[i].exp_found, dir_rows[i].exp_value});
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_capacity(CFG_W'(phase_cap[ph]));
      foreach (key_pool[j]) key_pool[j] = KEY_W'($urandom);
      // a pool a bit larger than the capacity keeps hits, updates and evictions mixed
      span = usable_slots(CFG_W'(phase_cap[ph])) + 4;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < phase_idle[ph])
          idle_gap($urandom_range(1, 24));
        else if ($urandom_range(59) == 0)
          wait_results_out();
        k = ($urandom_range(99) < 15) ? KEY_W'($urandom) : key_pool[$urandom_range(span - 1)];
        send_cmd(logic'($urandom_range(1)), k, VAL_W'($urandom), 1'b0, '0);
      end
    end

    wait_idle();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #(8 * 400000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
